// File: rtl/mksm_pkg.sv
// mksm_pkg: shared widths, register indexes and result type of the keyword matcher
// used by mksm_cell and multi_keyword_stream_matcher; no dependencies
package mksm_pkg;

  localparam int BYTE_W     = 8;
  localparam int PATTERN_W  = 64;
  localparam int LEN_W      = 4;
  localparam int TAG_W      = 8;
  localparam int SLOTS      = 4;
  localparam int SLOT_W     = 2;
  localparam int COUNT_W    = 3;
  localparam int SEEN_W     = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int LENGTHS_W  = SLOTS * LEN_W;
  localparam int TAGS_W     = SLOTS * TAG_W;

  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_LENGTHS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_TAGS    = 3'd6;

  typedef struct packed {
    logic              matched;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] keyword_index;
  } result_t;

endpackage

// File: rtl/mksm_cell.sv
// mksm_cell: one history byte of the keyword matcher plus its per-keyword byte compare
// depends on mksm_pkg
module mksm_cell #(
  parameter int KEYWORDS = 4
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         shift,
  input  logic [mksm_pkg::BYTE_W-1:0]                  byte_load,
  input  logic [KEYWORDS-1:0][mksm_pkg::BYTE_W-1:0]    pat_byte,
  output logic [mksm_pkg::BYTE_W-1:0]                  byte_q,
  output logic [KEYWORDS-1:0]                          eq
);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_q <= '0;
    end else if (shift) begin
      byte_q <= byte_load;
    end
  end

  // compare the byte this cell takes on at the shift
  always_comb begin
    for (int k = 0; k < KEYWORDS; k++) begin
      eq[k] = (byte_load == pat_byte[k]);
    end
  end

endmodule

// File: rtl/multi_keyword_stream_matcher.sv
// multi_keyword_stream_matcher: top level, history cell chain, keyword select and result register
// depends on mksm_pkg and mksm_cell
//
// usage
//   input channel: in_valid / in_stall with byte_in, one stream byte per transaction
//   output channel: out_valid / out_stall with matched, tag, keyword_index, one
//   result transaction for every input transaction, in order
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, index 0 keyword_count, 1..4 pattern_0..3, 5 keyword_lengths,
//   6 keyword_tags, index 7 ignored; write only while no result is outstanding
// latency: the result of a byte appears in the output register one cycle after
//   the byte is taken
// throughput: one byte per cycle; the byte compare of all history cells and the
//   four-way priority select fit between the history and the result register
// stall: a single output register parts the sides; while it holds a result and
//   out_stall is high, in_stall is raised and nothing moves
// reset: rst (synchronous) clears history, the byte count, all config registers
//   and the output valid; no clearing pass is needed
module multi_keyword_stream_matcher #(
  parameter int KEYWORDS = 4,
  parameter int MAX_LEN  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mksm_pkg::BYTE_W-1:0]         byte_in,
  // result stream
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                matched,
  output logic [mksm_pkg::TAG_W-1:0]          tag,
  output logic [mksm_pkg::SLOT_W-1:0]         keyword_index,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mksm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mksm_pkg::PATTERN_W-1:0]      cfg_data
);

  localparam int BW = mksm_pkg::BYTE_W;
  localparam int LW = mksm_pkg::LEN_W;
  localparam int TW = mksm_pkg::TAG_W;

  // configuration registers
  logic [mksm_pkg::COUNT_W-1:0]   keyword_count;
  logic [mksm_pkg::PATTERN_W-1:0] pattern [mksm_pkg::SLOTS];
  logic [mksm_pkg::LENGTHS_W-1:0] keyword_lengths;
  logic [mksm_pkg::TAGS_W-1:0]    keyword_tags;

  // stream state
  logic [mksm_pkg::SEEN_W-1:0]    bytes_seen;
  logic [mksm_pkg::SEEN_W-1:0]    bytes_seen_next;
  logic [BW-1:0]                  hist [MAX_LEN];
  logic [KEYWORDS-1:0]            eq   [MAX_LEN];

  // handshake
  logic                           out_ready;
  logic                           in_fire;

  // keyword evaluation
  logic [mksm_pkg::COUNT_W-1:0]   count_eff;
  logic [KEYWORDS-1:0]            hit;
  mksm_pkg::result_t              result_next;
  mksm_pkg::result_t              result;

  assign cfg_ready = 1'b1;

  // output register frees up when empty or when its result leaves this cycle
  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = !out_ready;
  assign in_fire   = in_valid && out_ready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_count   <= '0;
      keyword_lengths <= '0;
      keyword_tags    <= '0;
      for (int s = 0; s < mksm_pkg::SLOTS; s++) begin
        pattern[s] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mksm_pkg::REG_KEYWORD_COUNT: begin
          keyword_count <= cfg_data[mksm_pkg::COUNT_W-1:0];
        end
        mksm_pkg::REG_PATTERN_0: begin
          pattern[0] <= cfg_data;
        end
        mksm_pkg::REG_PATTERN_1: begin
          pattern[1] <= cfg_data;
        end
        mksm_pkg::REG_PATTERN_2: begin
          pattern[2] <= cfg_data;
        end
        mksm_pkg::REG_PATTERN_3: begin
          pattern[3] <= cfg_data;
        end
        mksm_pkg::REG_KEYWORD_LENGTHS: begin
          keyword_lengths <= cfg_data[mksm_pkg::LENGTHS_W-1:0];
        end
        mksm_pkg::REG_KEYWORD_TAGS: begin
          keyword_tags <= cfg_data[mksm_pkg::TAGS_W-1:0];
        end
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------- history chain
  // cell 0 takes the new byte, cell j takes what cell j-1 held; each cell
  // compares its incoming byte with byte j of every keyword
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    logic [BW-1:0]                load;
    logic [KEYWORDS-1:0][BW-1:0]  pat_byte;

    if (j == 0) begin : g_head
      assign load = byte_in;
    end else begin : g_body
      assign load = hist[j-1];
    end

    for (genvar k = 0; k < KEYWORDS; k++) begin : g_pat
      assign pat_byte[k] = pattern[k][BW*j +: BW];
    end

    mksm_cell #(
      .KEYWORDS (KEYWORDS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (in_fire),
      .byte_load (load),
      .pat_byte  (pat_byte),
      .byte_q    (hist[j]),
      .eq        (eq[j])
    );
  end

  // saturating count of bytes received
  assign bytes_seen_next = (bytes_seen == mksm_pkg::SEEN_MAX) ? bytes_seen
                                                               : bytes_seen + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (in_fire) begin
      bytes_seen <= bytes_seen_next;
    end
  end

  // ------------------------------------------------------- keyword matching
  // slot count above the number of keyword units is clamped
  assign count_eff = (keyword_count > mksm_pkg::COUNT_W'(KEYWORDS))
                   ? mksm_pkg::COUNT_W'(KEYWORDS) : keyword_count;

  always_comb begin
    logic [LW-1:0] len;
    for (int k = 0; k < KEYWORDS; k++) begin
      len    = keyword_lengths[LW*k +: LW];
      // slot in use, length in range and enough bytes seen (an empty keyword in a used slot always hits)
      hit[k] = (mksm_pkg::COUNT_W'(k) < count_eff) && (len <= LW'(MAX_LEN))
               && (bytes_seen_next >= len);
      for (int j = 0; j < MAX_LEN; j++) begin
        if ((LW'(j) < len) && !eq[j][k]) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // lowest matching slot wins
  always_comb begin
    result_next = '0;
    for (int k = KEYWORDS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        result_next.matched       = 1'b1;
        result_next.tag           = keyword_tags[TW*k +: TW];
        result_next.keyword_index = mksm_pkg::SLOT_W'(k);
      end
    end
  end

  // --------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign matched       = result.matched;
  assign tag           = result.tag;
  assign keyword_index = result.keyword_index;

  // ------------------------------------------------------------- assertions
  // a miss reports tag and slot as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !matched) |-> (tag == '0 && keyword_index == '0))
    else $error("miss result carries nonzero tag or slot");

  // byte count steps by one per accepted byte until it saturates
  a_seen_step: assert property (@(posedge clk) disable iff (rst)
    (in_fire && bytes_seen != mksm_pkg::SEEN_MAX) |=>
      (bytes_seen == $past(bytes_seen) + 1'b1))
    else $error("byte count did not advance");

  // the newest history cell holds the last accepted byte
  a_hist_head: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (hist[0] == $past(byte_in)))
    else $error("history head lost the accepted byte");

endmodule
